@@ src/mcfe_pkg.sv @@
// Shared constants and types of the motor command frame encoder.
package mcfe_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned DIFF_W      = VALUE_W + 1;
   localparam int unsigned PROD_W      = 2 * VALUE_W;
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned POS_BITS    = 16;
   localparam int unsigned FIELD_BITS  = 12;
   localparam int unsigned PAYLOAD_W   = 64;
   localparam int unsigned NUM_FIELDS  = 5;
   localparam int unsigned CSR_INDEX_W = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POS_MIN    = 3'd0,
      REG_POS_SCALE  = 3'd1,
      REG_VEL_MIN    = 3'd2,
      REG_VEL_SCALE  = 3'd3,
      REG_KP_SCALE   = 3'd4,
      REG_KD_SCALE   = 3'd5,
      REG_TORQ_MIN   = 3'd6,
      REG_TORQ_SCALE = 3'd7
   } mcfe_reg_type;

   // Clip mask bit positions.
   localparam int unsigned CLIP_POS  = 0;
   localparam int unsigned CLIP_VEL  = 1;
   localparam int unsigned CLIP_KP   = 2;
   localparam int unsigned CLIP_KD   = 3;
   localparam int unsigned CLIP_TORQ = 4;

   typedef struct packed {
      logic signed [VALUE_W-1:0] pos_min;
      logic        [VALUE_W-1:0] pos_scale;
      logic signed [VALUE_W-1:0] vel_min;
      logic        [VALUE_W-1:0] vel_scale;
      logic        [VALUE_W-1:0] kp_scale;
      logic        [VALUE_W-1:0] kd_scale;
      logic signed [VALUE_W-1:0] torq_min;
      logic        [VALUE_W-1:0] torq_scale;
   } mcfe_cfg_type;

   // Load enables of the three pipeline stages.
   typedef struct packed {
      logic diff_en;
      logic prod_en;
      logic code_en;
   } mcfe_adv_type;

endpackage

@@ src/mcfe_csr.sv @@
// Configuration register file of the motor command frame encoder.
module mcfe_csr import mcfe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_wdata,
   output mcfe_cfg_type           cfg
);

   mcfe_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (mcfe_reg_type'(csr_index))
            REG_POS_MIN:    cfg_in.pos_min    = csr_wdata;
            REG_POS_SCALE:  cfg_in.pos_scale  = csr_wdata;
            REG_VEL_MIN:    cfg_in.vel_min    = csr_wdata;
            REG_VEL_SCALE:  cfg_in.vel_scale  = csr_wdata;
            REG_KP_SCALE:   cfg_in.kp_scale   = csr_wdata;
            REG_KD_SCALE:   cfg_in.kd_scale   = csr_wdata;
            REG_TORQ_MIN:   cfg_in.torq_min   = csr_wdata;
            REG_TORQ_SCALE: cfg_in.torq_scale = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/mcfe_lane.sv @@
// One quantizer lane: subtract, multiply, then clamp to a code of BITS bits.
module mcfe_lane import mcfe_pkg::*; #(
   parameter int unsigned BITS = FIELD_BITS
) (
   input  logic                      clock,
   input  mcfe_adv_type              adv,
   input  logic signed [VALUE_W-1:0] value,
   input  logic signed [VALUE_W-1:0] lo,
   input  logic        [VALUE_W-1:0] scale,
   output logic        [BITS-1:0]    code,
   output logic                      clip
);

   localparam logic [BITS-1:0] TOP = {BITS{1'b1}};

   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic        [VALUE_W-1:0] scale_ff;
   logic        [PROD_W-1:0]  prod_ff, prod_in;
   logic                      neg_ff, zero_ff;
   logic        [BITS-1:0]    code_ff, code_in;
   logic                      clip_ff, clip_in;

   assign diff_in = {value[VALUE_W-1], value} - {lo[VALUE_W-1], lo};
   assign prod_in = diff_ff[VALUE_W-1:0] * scale_ff;

   always_comb begin
      code_in = prod_ff[FRAC_BITS +: BITS];
      clip_in = 1'b0;
      priority if (zero_ff) begin
         code_in = '0;
      end else if (neg_ff) begin
         code_in = '0;
         clip_in = 1'b1;
      end else if (|prod_ff[PROD_W-1:FRAC_BITS+BITS]) begin
         code_in = TOP;
         clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.diff_en) begin
         diff_ff  <= diff_in;
         scale_ff <= scale;
      end
      if (adv.prod_en) begin
         prod_ff <= prod_in;
         neg_ff  <= diff_ff[DIFF_W-1];
         zero_ff <= (scale_ff == '0);
      end
      if (adv.code_en) begin
         code_ff <= code_in;
         clip_ff <= clip_in;
      end
   end

   assign code = code_ff;
   assign clip = clip_ff;

endmodule

@@ src/mit_command_frame_encoder_unit.sv @@
// Each accepted item passes three registered stages in order: difference, product, clamp.
// One item per cycle unless stalled; each field has its own 32x32 multiplier stage.
// A held result stalls only the full stages behind it; an empty stage keeps loading,
// so the input stalls only while all three stages hold items and the output waits.
// Reset (synchronous, active high) clears the stage valid bits and all eight
// configuration registers to zero.
module mit_command_frame_encoder_unit import mcfe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_target_position,
   input  logic signed [VALUE_W-1:0] req_target_velocity,
   input  logic signed [VALUE_W-1:0] req_stiffness_gain,
   input  logic signed [VALUE_W-1:0] req_damping_gain,
   input  logic signed [VALUE_W-1:0] req_feedforward_torque,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PAYLOAD_W-1:0]      rsp_payload,
   output logic [NUM_FIELDS-1:0]     rsp_clip_mask,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [VALUE_W-1:0]        csr_wdata
);

   mcfe_cfg_type   cfg;
   mcfe_adv_type   adv;
   logic [2:0]     vld_ff, vld_in;
   logic [POS_BITS-1:0]   pos_code;
   logic [FIELD_BITS-1:0] vel_code, kp_code, kd_code, torq_code;
   logic [NUM_FIELDS-1:0] clip;

   mcfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A stage may load when it is empty or when the stage after it loads too.
   always_comb begin
      adv.code_en = !vld_ff[2] || rsp_ready;
      adv.prod_en = !vld_ff[1] || adv.code_en;
      adv.diff_en = !vld_ff[0] || adv.prod_en;
      vld_in[0]   = adv.diff_en ? req_valid : vld_ff[0];
      vld_in[1]   = adv.prod_en ? vld_ff[0] : vld_ff[1];
      vld_in[2]   = adv.code_en ? vld_ff[1] : vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv.diff_en;
   assign rsp_valid = vld_ff[2];

   mcfe_lane #(.BITS(POS_BITS)) u_pos (
      .clock (clock), .adv (adv), .value (req_target_position),
      .lo (cfg.pos_min), .scale (cfg.pos_scale),
      .code (pos_code), .clip (clip[CLIP_POS])
   );

   mcfe_lane #(.BITS(FIELD_BITS)) u_vel (
      .clock (clock), .adv (adv), .value (req_target_velocity),
      .lo (cfg.vel_min), .scale (cfg.vel_scale),
      .code (vel_code), .clip (clip[CLIP_VEL])
   );

   // Stiffness and damping ranges start at zero.
   mcfe_lane #(.BITS(FIELD_BITS)) u_kp (
      .clock (clock), .adv (adv), .value (req_stiffness_gain),
      .lo ('0), .scale (cfg.kp_scale),
      .code (kp_code), .clip (clip[CLIP_KP])
   );

   mcfe_lane #(.BITS(FIELD_BITS)) u_kd (
      .clock (clock), .adv (adv), .value (req_damping_gain),
      .lo ('0), .scale (cfg.kd_scale),
      .code (kd_code), .clip (clip[CLIP_KD])
   );

   mcfe_lane #(.BITS(FIELD_BITS)) u_torq (
      .clock (clock), .adv (adv), .value (req_feedforward_torque),
      .lo (cfg.torq_min), .scale (cfg.torq_scale),
      .code (torq_code), .clip (clip[CLIP_TORQ])
   );

   assign rsp_payload   = {pos_code, vel_code, kp_code, kd_code, torq_code};
   assign rsp_clip_mask = clip;

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (vld_ff[0] && vld_ff[1] && vld_ff[2]))
      else $error("input stalled while a pipeline stage was empty");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted item did not enter the first stage");

   a_pos_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clip_mask[CLIP_POS]) |->
         (pos_code == '0 || pos_code == {POS_BITS{1'b1}}))
      else $error("clamped position code is not at a range end");

   a_torq_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clip_mask[CLIP_TORQ]) |->
         (torq_code == '0 || torq_code == {FIELD_BITS{1'b1}}))
      else $error("clamped torque code is not at a range end");

endmodule
